// File: sv/gpd_pkg.sv
package gpd_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_RECT_WIDTH  = 3'd0;
    localparam logic [2:0] REG_PACKED24    = 3'd1;
    localparam logic [2:0] REG_RED_MAX     = 3'd2;
    localparam logic [2:0] REG_GREEN_MAX   = 3'd3;
    localparam logic [2:0] REG_BLUE_MAX    = 3'd4;
    localparam logic [2:0] REG_RED_SHIFT   = 3'd5;
    localparam logic [2:0] REG_GREEN_SHIFT = 3'd6;
    localparam logic [2:0] REG_BLUE_SHIFT  = 3'd7;

    localparam int unsigned NUM_CHANNELS = 3;
    localparam logic [7:0]  BYTE_MAX     = 8'hFF;

    // control of the item held in the reconstruction stage
    typedef struct packed {
        logic valid;
        logic first_row;
        logic col_zero;
        logic fwd;
    } gpd_ctl_t;

endpackage

// File: sv/gradient_predictor_pixel_decoder.sv
// Gradient predictor pixel decoder: takes one residual pixel per transfer in raster
// order and returns one reconstructed pixel per transfer, at a sustained rate of one
// pixel per clock while out_stall is low. The row above is read from the row memory
// (MAX_WIDTH entries of three channels) by a registered read; the gradient
// prediction, whose left-pixel loop closes within its own stage, then forms the
// pixel, which goes to the output register. Up to two pixels are held inside (one in
// reconstruction, one in the output register). start_rect marks the first pixel of
// a rectangle; the first row after reset or start_rect sees a zero row above. The
// row memory is not cleared and needs no setup time after reset. Configuration
// must be written only while no pixel is in flight; the block does not enforce it.
module gradient_predictor_pixel_decoder #(
    parameter int MAX_WIDTH    = 2048,
    parameter int CHANNEL_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] residual_pixel,
    input  logic        start_rect,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pixel_out
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [11:0]            rect_width_reg;
    logic                   packed24_reg;
    logic [2:0][15:0]       max_reg;
    logic [2:0][4:0]        shift_reg;

    logic                        s1_adv;
    logic                        wr_en;
    logic [COL_W-1:0]            wr_addr;
    logic [3*CHANNEL_BITS-1:0]   wr_data;
    logic                        rd_en;
    logic [COL_W-1:0]            rd_addr;
    logic [3*CHANNEL_BITS-1:0]   rd_data;
    gpd_pkg::gpd_ctl_t           s1_ctl;
    logic [COL_W-1:0]            s1_col;
    logic [2:0][CHANNEL_BITS-1:0] s1_res;
    logic [3*CHANNEL_BITS-1:0]   s1_fwd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_width_reg <= 12'd1;
            packed24_reg   <= 1'b0;
            max_reg[0]     <= 16'd255;
            max_reg[1]     <= 16'd255;
            max_reg[2]     <= 16'd255;
            shift_reg[0]   <= 5'd16;
            shift_reg[1]   <= 5'd8;
            shift_reg[2]   <= 5'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gpd_pkg::REG_RECT_WIDTH:  rect_width_reg <= cfg_data[11:0];
                gpd_pkg::REG_PACKED24:    packed24_reg   <= cfg_data[0];
                gpd_pkg::REG_RED_MAX:     max_reg[0]     <= cfg_data;
                gpd_pkg::REG_GREEN_MAX:   max_reg[1]     <= cfg_data;
                gpd_pkg::REG_BLUE_MAX:    max_reg[2]     <= cfg_data;
                gpd_pkg::REG_RED_SHIFT:   shift_reg[0]   <= cfg_data[4:0];
                gpd_pkg::REG_GREEN_SHIFT: shift_reg[1]   <= cfg_data[4:0];
                gpd_pkg::REG_BLUE_SHIFT:  shift_reg[2]   <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    gpd_ram #(
        .WIDTH (3*CHANNEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    gpd_fetch #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_fetch (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .residual_pixel (residual_pixel),
        .start_rect     (start_rect),
        .rect_width     (rect_width_reg),
        .packed24       (packed24_reg),
        .shifts         (shift_reg),
        .s1_adv         (s1_adv),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .s1_ctl         (s1_ctl),
        .s1_col         (s1_col),
        .s1_res         (s1_res),
        .s1_fwd_data    (s1_fwd_data)
    );

    gpd_recon #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_recon (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1_ctl      (s1_ctl),
        .s1_col      (s1_col),
        .s1_res      (s1_res),
        .s1_fwd_data (s1_fwd_data),
        .rd_data     (rd_data),
        .packed24    (packed24_reg),
        .channel_max (max_reg),
        .shifts      (shift_reg),
        .out_stall   (out_stall),
        .s1_adv      (s1_adv),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .out_valid   (out_valid),
        .pixel_out   (pixel_out)
    );

endmodule

// File: sv/gpd_ram.sv
module gpd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/gpd_fetch.sv
module gpd_fetch #(
    parameter int MAX_WIDTH    = 2048,
    parameter int CHANNEL_BITS = 16,
    localparam int COL_W       = $clog2(MAX_WIDTH),
    localparam int CW          = (COL_W + 1 > 12) ? COL_W + 1 : 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [31:0]                        residual_pixel,
    input  logic                               start_rect,
    input  logic [11:0]                        rect_width,
    input  logic                               packed24,
    input  logic [2:0][4:0]                    shifts,
    input  logic                               s1_adv,
    input  logic                               wr_en,
    input  logic [COL_W-1:0]                   wr_addr,
    input  logic [3*CHANNEL_BITS-1:0]          wr_data,
    output logic                               rd_en,
    output logic [COL_W-1:0]                   rd_addr,
    output gpd_pkg::gpd_ctl_t                  s1_ctl,
    output logic [COL_W-1:0]                   s1_col,
    output logic [2:0][CHANNEL_BITS-1:0]       s1_res,
    output logic [3*CHANNEL_BITS-1:0]          s1_fwd_data
);

    logic [COL_W-1:0]                 column_reg;
    logic                             first_row_reg;
    logic                             s1_valid_reg;
    logic                             s1_first_reg;
    logic                             s1_fwd_reg;
    logic [COL_W-1:0]                 s1_col_reg;
    logic [2:0][CHANNEL_BITS-1:0]     s1_res_reg;
    logic [3*CHANNEL_BITS-1:0]        s1_fwd_data_reg;

    logic                             accept;
    logic [COL_W-1:0]                 cur_col;
    logic                             cur_first;
    logic [COL_W:0]                   next_col;
    logic                             end_row;
    logic [2:0][CHANNEL_BITS-1:0]     res;
    logic [2:0][31:0]                 shifted;

    assign in_stall  = s1_valid_reg && !s1_adv;
    assign accept    = in_valid && !in_stall;
    assign cur_col   = start_rect ? '0 : column_reg;
    assign cur_first = start_rect || first_row_reg;
    assign next_col  = {1'b0, cur_col} + (COL_W+1)'(1);
    // row ends at the configured width, or at the store depth for wider settings
    assign end_row   = (CW'(next_col) >= CW'(rect_width))
                    || (next_col == (COL_W+1)'(MAX_WIDTH));

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            shifted[c] = residual_pixel >> shifts[c];
            if (packed24)
            begin
                res[c] = CHANNEL_BITS'(residual_pixel[8*c +: 8]);
            end
            else
            begin
                res[c] = shifted[c][CHANNEL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            first_row_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
        end
        else if (accept)
        begin
            column_reg    <= end_row ? '0 : next_col[COL_W-1:0];
            first_row_reg <= end_row ? 1'b0 : cur_first;
            s1_valid_reg  <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg  <= 1'b0;
        end
    end

    // payload of the stage; the row entry written in the same cycle is caught here
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg    <= cur_first;
            s1_col_reg      <= cur_col;
            s1_res_reg      <= res;
            s1_fwd_reg      <= wr_en && (wr_addr == cur_col);
            s1_fwd_data_reg <= wr_data;
        end
    end

    assign rd_en       = accept;
    assign rd_addr     = cur_col;

    assign s1_ctl.valid     = s1_valid_reg;
    assign s1_ctl.first_row = s1_first_reg;
    assign s1_ctl.col_zero  = (s1_col_reg == '0);
    assign s1_ctl.fwd       = s1_fwd_reg;
    assign s1_col           = s1_col_reg;
    assign s1_res           = s1_res_reg;
    assign s1_fwd_data      = s1_fwd_data_reg;

endmodule

// File: sv/gpd_recon.sv
module gpd_recon #(
    parameter int MAX_WIDTH    = 2048,
    parameter int CHANNEL_BITS = 16,
    localparam int COL_W       = $clog2(MAX_WIDTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gpd_pkg::gpd_ctl_t                  s1_ctl,
    input  logic [COL_W-1:0]                   s1_col,
    input  logic [2:0][CHANNEL_BITS-1:0]       s1_res,
    input  logic [3*CHANNEL_BITS-1:0]          s1_fwd_data,
    input  logic [3*CHANNEL_BITS-1:0]          rd_data,
    input  logic                               packed24,
    input  logic [2:0][15:0]                   channel_max,
    input  logic [2:0][4:0]                    shifts,
    input  logic                               out_stall,
    output logic                               s1_adv,
    output logic                               wr_en,
    output logic [COL_W-1:0]                   wr_addr,
    output logic [3*CHANNEL_BITS-1:0]          wr_data,
    output logic                               out_valid,
    output logic [31:0]                        pixel_out
);

    localparam int CB = CHANNEL_BITS;

    logic [2:0][CB-1:0]   left_reg;
    logic [2:0][CB-1:0]   upper_left_reg;
    logic                 out_valid_reg;
    logic [31:0]          pixel_out_reg;

    logic [3*CB-1:0]      stored;
    logic [2:0][CB-1:0]   above;
    logic [2:0][CB-1:0]   maxv;
    logic [2:0][CB+1:0]   est;
    logic [2:0][CB-1:0]   clamped;
    logic [2:0][CB-1:0]   pred;
    logic [2:0][CB-1:0]   pix;
    logic [31:0]          packed_pix;

    assign s1_adv = s1_ctl.valid && !(out_valid_reg && out_stall);
    assign stored = s1_ctl.fwd ? s1_fwd_data : rd_data;

    always_comb
    begin
        packed_pix = '0;
        for (int c = 0; c < 3; c++)
        begin
            above[c] = s1_ctl.first_row ? '0 : stored[c*CB +: CB];
            maxv[c]  = packed24 ? CB'(gpd_pkg::BYTE_MAX) : channel_max[c][CB-1:0];
            est[c]   = {2'b00, above[c]} + {2'b00, left_reg[c]}
                     - {2'b00, upper_left_reg[c]};
            // gradient estimate clamped to 0..max
            if (est[c][CB+1])
            begin
                clamped[c] = '0;
            end
            else if (est[c][CB:0] > {1'b0, maxv[c]})
            begin
                clamped[c] = maxv[c];
            end
            else
            begin
                clamped[c] = est[c][CB-1:0];
            end
            pred[c]    = s1_ctl.col_zero ? above[c] : clamped[c];
            pix[c]     = (s1_res[c] + pred[c]) & maxv[c];
            packed_pix = packed_pix | (32'(pix[c]) << shifts[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            upper_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (s1_adv)
        begin
            left_reg       <= pix;
            upper_left_reg <= above;
            out_valid_reg  <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            pixel_out_reg <= packed_pix;
        end
    end

    assign wr_en     = s1_adv;
    assign wr_addr   = s1_col;
    assign wr_data   = pix;
    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;

endmodule

// File: sv/gpd_checker.sv
module gpd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] pixel_out
);

    logic [1:0] count_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    // pixels taken in but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (in_xfer && !out_xfer)
        begin
            count_reg <= count_reg + 2'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_out))
        else $error("stalled output pixel changed");

    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3 && (out_valid ? count_reg != 2'd0 : 1'b1))
        else $error("pixel count inside the decoder out of range");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 && out_stall |-> in_stall)
        else $error("transfer accepted with both stages full");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && count_reg == 2'd0 |=> ##1 out_valid)
        else $error("pixel not delivered two cycles after transfer");

endmodule

bind gradient_predictor_pixel_decoder gpd_checker u_gpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out)
);
